[sv/alist_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// alist_pkg: shared types and constants of the array list core
// Sizes of the list storage, request and status codes, and the control
// structures handed between the decoder, the cells and the top level.
// ---------------------------------------------------------------------------
package alist_pkg;

  localparam int DEPTH   = 16;
  localparam int WIDTH   = 32;
  localparam int CNT_W   = $clog2(DEPTH + 1);
  localparam int OP_W    = 2;
  localparam int POS_W   = 5;
  localparam int VAL_W   = 32;
  localparam int STAT_W  = 2;
  localparam int IN_W    = 40;
  localparam int OUT_W   = 40;

  typedef enum logic [OP_W-1:0] {
    OP_READ   = 2'd0,
    OP_WRITE  = 2'd1,
    OP_INSERT = 2'd2,
    OP_DELETE = 2'd3
  } op_e;

  typedef enum logic [STAT_W-1:0] {
    ST_OK    = 2'd0,
    ST_BOUND = 2'd1,
    ST_FULL  = 2'd2
  } status_e;

  // Decoded request: what the list does and what it answers
  typedef struct packed {
    status_e          status;
    logic             rd_ok;
    logic             wr_ok;
    logic             ins_ok;
    logic             del_ok;
    logic [CNT_W-1:0] count_nxt;
  } dec_t;

  // Per-cell command: where the cell takes its next value from
  typedef struct packed {
    logic from_left;
    logic from_right;
    logic load;
  } cell_cmd_t;

endpackage
`default_nettype wire

[sv/alist_dec.sv]
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// alist_dec: request decoder
// Checks the position against the element count, picks the status and the
// count after the request.
// ---------------------------------------------------------------------------
module alist_dec (
  input  wire logic [alist_pkg::OP_W-1:0]  op_i,
  input  wire logic [alist_pkg::POS_W-1:0] pos_i,
  input  wire logic [alist_pkg::CNT_W-1:0] count_i,
  output alist_pkg::dec_t                  dec_o
);

  logic in_range;
  logic at_or_below;
  logic full;

  // Compare on a common wide scale
  assign in_range    = 32'(pos_i) <  32'(count_i);
  assign at_or_below = 32'(pos_i) <= 32'(count_i);
  assign full        = 32'(count_i) >= 32'(alist_pkg::DEPTH);

  always_comb begin
    dec_o           = '0;
    dec_o.status    = alist_pkg::ST_OK;
    dec_o.count_nxt = count_i;
    case (alist_pkg::op_e'(op_i))
      alist_pkg::OP_READ: begin
        if (in_range) dec_o.rd_ok = 1'b1;
        else          dec_o.status = alist_pkg::ST_BOUND;
      end
      alist_pkg::OP_WRITE: begin
        if (in_range) dec_o.wr_ok = 1'b1;
        else          dec_o.status = alist_pkg::ST_BOUND;
      end
      alist_pkg::OP_INSERT: begin
        // bound test first, then the full test
        if (!at_or_below) begin
          dec_o.status = alist_pkg::ST_BOUND;
        end else if (full) begin
          dec_o.status = alist_pkg::ST_FULL;
        end else begin
          dec_o.ins_ok    = 1'b1;
          dec_o.count_nxt = count_i + alist_pkg::CNT_W'(1);
        end
      end
      alist_pkg::OP_DELETE: begin
        if (in_range) begin
          dec_o.del_ok    = 1'b1;
          dec_o.count_nxt = count_i - alist_pkg::CNT_W'(1);
        end else begin
          dec_o.status = alist_pkg::ST_BOUND;
        end
      end
      default: dec_o.status = alist_pkg::ST_BOUND;
    endcase
  end

endmodule
`default_nettype wire

[sv/alist_cell.sv]
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// alist_cell: one list entry
// Holds one element; takes the left neighbour on insert, the right
// neighbour on delete, or the request value on a load.
// ---------------------------------------------------------------------------
module alist_cell (
  input  wire logic                        clk_i,
  input  wire alist_pkg::cell_cmd_t        cmd_i,
  input  wire logic [alist_pkg::WIDTH-1:0] left_i,
  input  wire logic [alist_pkg::WIDTH-1:0] right_i,
  input  wire logic [alist_pkg::WIDTH-1:0] val_i,
  output logic      [alist_pkg::WIDTH-1:0] data_o
);

  logic [alist_pkg::WIDTH-1:0] data_d, data_q;

  // Select the next entry value
  always_comb begin
    data_d = data_q;
    if (cmd_i.load)            data_d = val_i;
    else if (cmd_i.from_left)  data_d = left_i;
    else if (cmd_i.from_right) data_d = right_i;
  end

  // Payload register, no reset
  always_ff @(posedge clk_i) begin
    data_q <= data_d;
  end

  assign data_o = data_q;

endmodule
`default_nettype wire

[sv/array_list_insert_delete_core.sv]
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// array_list_insert_delete_core: ordered list in a row of shifting cells
// Each request reads, overwrites, inserts or deletes at a list position and
// answers with the entry read, the count, an empty flag and a status.
// ---------------------------------------------------------------------------
// Usage:
//   Requests enter on the s_ stream, one beat per request. Each request
//   gives exactly one result beat on the m_ stream, in order.
//   Latency: the result is presented in the cycle after the request beat.
//   Throughput: one request per cycle while results are taken. Every cell
//   shifts or holds in parallel, so an insert or delete moves the row at once.
//   The output register frees when its beat is taken, so a new request is
//   accepted in the same cycle the previous result leaves.
//   Reset empties the list (count zero); entry contents are not cleared and
//   are never visible, since only entries below the count can be read.
//   When the receiver stalls, the result beat holds and s_tready_o drops
//   until it is taken; no request is lost.
//   Unused values of op are not possible (all four codes are defined).
// ---------------------------------------------------------------------------
module array_list_insert_delete_core (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        s_tvalid_i,
  output logic                             s_tready_o,
  // s_tdata_i: [1:0] op, [6:2] position, [38:7] value, [39] zero
  input  wire logic [alist_pkg::IN_W-1:0]  s_tdata_i,
  output logic                             m_tvalid_o,
  input  wire logic                        m_tready_i,
  // m_tdata_o: [31:0] read_value, [36:32] count, [37] is_empty,
  //            [39:38] status
  output logic      [alist_pkg::OUT_W-1:0] m_tdata_o
);

  localparam int DEPTH = alist_pkg::DEPTH;
  localparam int WIDTH = alist_pkg::WIDTH;
  localparam int CNT_W = alist_pkg::CNT_W;
  localparam int IDX_W = $clog2(DEPTH);

  logic [alist_pkg::OP_W-1:0]  op;
  logic [alist_pkg::POS_W-1:0] pos;
  logic [WIDTH-1:0]            val;
  logic                        fire;
  alist_pkg::dec_t             dec;

  logic [CNT_W-1:0]            count_d, count_q;
  logic                        m_valid_d, m_valid_q;
  logic [alist_pkg::OUT_W-1:0] m_data_d, m_data_q;

  logic [WIDTH-1:0]            cell_data [DEPTH];
  alist_pkg::cell_cmd_t        cell_cmd  [DEPTH];
  logic [WIDTH-1:0]            rd_entry;

  // Unpack the request beat
  assign op   = s_tdata_i[1:0];
  assign pos  = s_tdata_i[6:2];
  assign val  = WIDTH'(s_tdata_i[38:7]);

  // Accept while the result slot is empty or being emptied
  assign s_tready_o = !m_valid_q || m_tready_i;
  assign fire       = s_tvalid_i && s_tready_o;

  alist_dec u_dec (
    .op_i    (op),
    .pos_i   (pos),
    .count_i (count_q),
    .dec_o   (dec)
  );

  // Row of cells, each handing its entry to its neighbours
  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic             at_pos;
    logic             past_pos;
    logic [WIDTH-1:0] left, right;

    assign at_pos   = 32'(pos) == 32'(i);
    assign past_pos = 32'(i) > 32'(pos);

    always_comb begin
      cell_cmd[i].load       = fire && (dec.wr_ok || dec.ins_ok) && at_pos;
      cell_cmd[i].from_left  = fire && dec.ins_ok && past_pos;
      cell_cmd[i].from_right = fire && dec.del_ok && (past_pos || at_pos);
    end

    if (i == 0) begin : g_first
      assign left = val;
    end else begin : g_left
      assign left = cell_data[i-1];
    end

    if (i == DEPTH - 1) begin : g_last
      assign right = cell_data[i];
    end else begin : g_right
      assign right = cell_data[i+1];
    end

    alist_cell u_cell (
      .clk_i   (clk_i),
      .cmd_i   (cell_cmd[i]),
      .left_i  (left),
      .right_i (right),
      .val_i   (val),
      .data_o  (cell_data[i])
    );
  end

  // Pick the entry at the request position
  assign rd_entry = cell_data[pos[IDX_W-1:0]];

  // Form the result beat and the next count
  always_comb begin
    count_d   = count_q;
    m_valid_d = m_valid_q;
    m_data_d  = m_data_q;
    if (m_tready_i) m_valid_d = 1'b0;
    if (fire) begin
      count_d          = dec.count_nxt;
      m_valid_d        = 1'b1;
      m_data_d[31:0]   = dec.rd_ok ? 32'(rd_entry) : 32'd0;
      m_data_d[36:32]  = 5'(dec.count_nxt);
      m_data_d[37]     = (dec.count_nxt == '0);
      m_data_d[39:38]  = dec.status;
    end
  end

  // Control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q   <= '0;
      m_valid_q <= 1'b0;
    end else begin
      count_q   <= count_d;
      m_valid_q <= m_valid_d;
    end
  end

  // Result payload, no reset
  always_ff @(posedge clk_i) begin
    m_data_q <= m_data_d;
  end

  assign m_tvalid_o = m_valid_q;
  assign m_tdata_o  = m_data_q;

  // Count never passes the capacity
  a_count_cap : assert property (@(posedge clk_i) disable iff (!rst_ni)
    32'(count_q) <= 32'(DEPTH))
    else $error("element count above capacity");

  // Successful insert grows the list by one
  a_ins_grow : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (fire && dec.ins_ok) |=> (count_q == $past(count_q) + CNT_W'(1)))
    else $error("insert did not grow the count");

  // Failed request leaves the count alone
  a_fail_hold : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (fire && dec.status != alist_pkg::ST_OK) |=> (count_q == $past(count_q)))
    else $error("failed request changed the count");

  // Empty flag agrees with the count field of a presented beat
  a_empty_flag : assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_valid_q |-> (m_data_q[37] == (m_data_q[36:32] == 5'd0)))
    else $error("empty flag disagrees with count");

endmodule
`default_nettype wire
